>>> sv/csmabo_pkg.sv
`default_nettype none
package csmabo_pkg;

  // Timer event codes carried in the mode field of an input beat.
  localparam logic [2:0] MODE_DIFS_CHECK    = 3'd0;
  localparam logic [2:0] MODE_CW_CHECK      = 3'd1;
  localparam logic [2:0] MODE_TRANSMIT      = 3'd2;
  localparam logic [2:0] MODE_ACCESS        = 3'd3;
  localparam logic [2:0] MODE_QUEUE_RECHECK = 3'd4;
  localparam logic [2:0] MODE_STATUS_CLEAR  = 3'd5;
  localparam logic [2:0] MODE_CW_CLEAR      = 3'd6;

  // Event to schedule next: the mode of that event plus one, zero for none.
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_DIFS_CHECK   = 3'd1;
  localparam logic [2:0] EV_CW_CHECK     = 3'd2;
  localparam logic [2:0] EV_TRANSMIT     = 3'd3;
  localparam logic [2:0] EV_ACCESS       = 3'd4;
  localparam logic [2:0] EV_RECHECK      = 3'd5;
  localparam logic [2:0] EV_STATUS_CLEAR = 3'd6;
  localparam logic [2:0] EV_CW_CLEAR     = 3'd7;

  // Delay kinds attached to a scheduled event.
  localparam logic [2:0] DK_SLOT        = 3'd0;
  localparam logic [2:0] DK_DIFS_INT    = 3'd1;
  localparam logic [2:0] DK_CW_INT      = 3'd2;
  localparam logic [2:0] DK_TX          = 3'd3;
  localparam logic [2:0] DK_TX_CW_DIFS  = 3'd4;
  localparam logic [2:0] DK_TX_SLOT     = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_CW_MIN      = 3'd0;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd1;
  localparam logic [2:0] REG_STAGE_LIMIT = 3'd2;
  localparam logic [2:0] REG_ROUND_LIMIT = 3'd3;
  localparam logic [2:0] REG_DIFS_SLOTS  = 3'd4;

  // One result beat; the first member listed last sits in the lowest bits.
  typedef struct packed {
    logic       last;
    logic       cw_zero_flag;
    logic       sending_flag;
    logic       run_ended;
    logic       packet_lost;
    logic       packet_sent;
    logic [2:0] delay_kind;
    logic [2:0] next_event;
  } result_t;

endpackage
`default_nettype wire

>>> sv/csma_ca_backoff_controller.sv
`default_nettype none
// CSMA/CA backoff sequencer for one node. Each input beat is one timer event
// (DIFS check, CW check, transmit, access, queue recheck, status clear, CW
// clear); the block updates its MAC state and returns one result beat (two
// for transmit, the second marked by tlast) naming the event to schedule next
// and its delay kind, plus sent, lost and run-ended flags and this node's
// sending and contention-zero flags. An accepted beat sits in an input
// register until the output buffer has room for its results. It is then
// evaluated by a single pass of logic against the state registers, and its
// results are written into a two-entry output buffer, from which the result
// beats are offered. The block takes one input beat per cycle as long as the
// output side drains one beat per cycle; a transmit event yields two output
// beats, so the rate is set by the output port. Configuration registers sit
// on the APB port at byte addresses 4*i and may only be written while no
// event is in flight.
module csma_ca_backoff_controller #(
  parameter int CW_WIDTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata, from bit 0: mode[2:0], queue_not_empty, other_sending,
  // other_cw_zero, random_value[15:0], two zero bits.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  // m_tdata, from bit 0: next_event[2:0], delay_kind[2:0], packet_sent,
  // packet_lost, run_ended, sending_flag, cw_zero_flag, five zero bits.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DRAW_W = 26;
  localparam int CMP_W  = (CW_WIDTH > DRAW_W) ? CW_WIDTH : DRAW_W;

  // Configuration registers.
  logic [9:0]  cw_min;
  logic [7:0]  retry_limit;
  logic [3:0]  stage_limit;
  logic [31:0] round_limit;
  logic [2:0]  difs_slots;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_min      <= 10'd32;
      retry_limit <= 8'd7;
      stage_limit <= 4'd6;
      round_limit <= 32'd1000;
      difs_slots  <= 3'd5;
    end else if (cfg_write) begin
      unique case (reg_index)
        csmabo_pkg::REG_CW_MIN:      cw_min      <= pwdata[9:0];
        csmabo_pkg::REG_RETRY_LIMIT: retry_limit <= pwdata[7:0];
        csmabo_pkg::REG_STAGE_LIMIT: stage_limit <= pwdata[3:0];
        csmabo_pkg::REG_ROUND_LIMIT: round_limit <= pwdata;
        csmabo_pkg::REG_DIFS_SLOTS:  difs_slots  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      csmabo_pkg::REG_CW_MIN:      prdata = {22'd0, cw_min};
      csmabo_pkg::REG_RETRY_LIMIT: prdata = {24'd0, retry_limit};
      csmabo_pkg::REG_STAGE_LIMIT: prdata = {28'd0, stage_limit};
      csmabo_pkg::REG_ROUND_LIMIT: prdata = round_limit;
      csmabo_pkg::REG_DIFS_SLOTS:  prdata = {29'd0, difs_slots};
      default:                     prdata = 32'd0;
    endcase
  end

  // Input register.
  logic        item_valid;
  logic [2:0]  mode;
  logic        queue_not_empty;
  logic        other_sending;
  logic        other_cw_zero;
  logic [15:0] random_value;

  logic s_accept;
  logic evaluate;

  assign s_tready = !item_valid || evaluate;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_accept) begin
      item_valid <= 1'b1;
    end else if (evaluate) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      mode            <= s_tdata[2:0];
      queue_not_empty <= s_tdata[3];
      other_sending   <= s_tdata[4];
      other_cw_zero   <= s_tdata[5];
      random_value    <= s_tdata[21:6];
    end
  end

  // MAC state.
  logic                medium_busy, medium_busy_next;
  logic [2:0]          difs_count, difs_count_next;
  logic [CW_WIDTH-1:0] cw_count, cw_count_next;
  logic                cw_valid, cw_valid_next;
  logic [3:0]          backoff_stage, backoff_stage_next;
  logic [7:0]          retry_count, retry_count_next;
  logic                first_done, first_done_next;
  logic                sending_status, sending_status_next;
  logic [31:0]         round_count, round_count_next;

  // Contention draw: 1 + ((random_value * (W - 1)) >> 16), W = cw_min << stage.
  logic [24:0]         window;
  logic [24:0]         window_m1;
  logic [40:0]         draw_prod;
  logic [DRAW_W-1:0]   draw_raw;
  logic [CMP_W-1:0]    draw_ext;
  logic [CMP_W-1:0]    cw_max_ext;
  logic [CW_WIDTH-1:0] draw;

  always_comb begin
    window     = 25'(cw_min) << backoff_stage;
    window_m1  = window - 25'd1;
    draw_prod  = 41'(random_value) * 41'(window_m1);
    if (window <= 25'd1) begin
      draw_raw = DRAW_W'(1);
    end else begin
      draw_raw = DRAW_W'(draw_prod[40:16]) + DRAW_W'(1);
    end
    draw_ext   = CMP_W'(draw_raw);
    cw_max_ext = CMP_W'({CW_WIDTH{1'b1}});
    draw = (draw_ext > cw_max_ext) ? CW_WIDTH'(cw_max_ext) : CW_WIDTH'(draw_ext);
  end

  // Single evaluation pass for the item in the input register.
  csmabo_pkg::result_t res0, res1;
  logic                two_results;
  logic [2:0]          ev0, dk0;
  logic                sent0, lost0, ended0, last0;
  logic                collided;
  logic [2:0]          difs_inc;
  logic                cw_nonzero;
  logic [CW_WIDTH-1:0] cw_dec;
  logic [31:0]         round_inc;

  always_comb begin
    medium_busy_next    = medium_busy;
    difs_count_next     = difs_count;
    cw_count_next       = cw_count;
    cw_valid_next       = cw_valid;
    backoff_stage_next  = backoff_stage;
    retry_count_next    = retry_count;
    first_done_next     = first_done;
    sending_status_next = sending_status;
    round_count_next    = round_count;
    two_results         = 1'b0;
    ev0                 = csmabo_pkg::EV_NONE;
    dk0                 = csmabo_pkg::DK_SLOT;
    sent0               = 1'b0;
    lost0               = 1'b0;
    ended0              = 1'b0;
    last0               = 1'b1;
    collided            = 1'b0;
    difs_inc            = difs_count + 3'd1;
    cw_nonzero          = !cw_valid || (cw_count != '0);
    cw_dec              = cw_count - CW_WIDTH'(1);
    round_inc           = (round_count != 32'hFFFF_FFFF) ? round_count + 32'd1
                                                         : round_count;

    case (mode)
      csmabo_pkg::MODE_DIFS_CHECK: begin
        if (!medium_busy && (difs_count < difs_slots)) begin
          if (difs_inc == difs_slots) begin
            difs_count_next = 3'd0;
            if (!first_done) begin
              sending_status_next = 1'b1;
              ev0 = csmabo_pkg::EV_TRANSMIT;
              dk0 = csmabo_pkg::DK_SLOT;
            end else begin
              if (!cw_valid) begin
                cw_count_next = draw;
                cw_valid_next = 1'b1;
              end
              ev0 = csmabo_pkg::EV_CW_CHECK;
              dk0 = csmabo_pkg::DK_CW_INT;
            end
          end else begin
            difs_count_next = difs_inc;
            ev0 = csmabo_pkg::EV_DIFS_CHECK;
            dk0 = csmabo_pkg::DK_DIFS_INT;
          end
        end else begin
          // Busy medium, or DIFS can never complete: wait out the transmission.
          difs_count_next = 3'd0;
          first_done_next = 1'b1;
          ev0 = csmabo_pkg::EV_DIFS_CHECK;
          dk0 = csmabo_pkg::DK_TX;
        end
      end
      csmabo_pkg::MODE_CW_CHECK: begin
        if (!medium_busy && cw_nonzero) begin
          if (cw_valid) begin
            cw_count_next = cw_dec;
          end
          if (cw_valid && (cw_dec == '0)) begin
            ev0 = csmabo_pkg::EV_TRANSMIT;
            dk0 = csmabo_pkg::DK_SLOT;
          end else begin
            ev0 = csmabo_pkg::EV_CW_CHECK;
            dk0 = csmabo_pkg::DK_CW_INT;
          end
        end else if (medium_busy && cw_nonzero) begin
          ev0 = csmabo_pkg::EV_DIFS_CHECK;
          dk0 = csmabo_pkg::DK_TX_CW_DIFS;
        end
      end
      csmabo_pkg::MODE_TRANSMIT: begin
        medium_busy_next = 1'b1;
        two_results      = 1'b1;
        last0            = 1'b0;
        if (!first_done) begin
          first_done_next = 1'b1;
          if (other_sending) begin
            retry_count_next = (retry_count != 8'hFF) ? retry_count + 8'd1 : retry_count;
            collided = 1'b1;
          end
          ev0 = csmabo_pkg::EV_STATUS_CLEAR;
        end else begin
          if (other_cw_zero) begin
            retry_count_next = (retry_count != 8'hFF) ? retry_count + 8'd1 : retry_count;
            backoff_stage_next = (backoff_stage != 4'hF) ? backoff_stage + 4'd1
                                                         : backoff_stage;
            collided = 1'b1;
          end
          ev0 = csmabo_pkg::EV_CW_CLEAR;
        end
        dk0 = csmabo_pkg::DK_SLOT;
        if (collided) begin
          if (backoff_stage_next > stage_limit) begin
            backoff_stage_next = stage_limit;
          end
          if (retry_count_next > retry_limit) begin
            retry_count_next   = 8'd0;
            backoff_stage_next = 4'd0;
            lost0              = queue_not_empty;
          end
        end else begin
          sent0              = queue_not_empty;
          backoff_stage_next = 4'd0;
          retry_count_next   = 8'd0;
        end
      end
      csmabo_pkg::MODE_ACCESS: begin
        round_count_next = round_inc;
        if (round_inc >= round_limit) begin
          ended0 = 1'b1;
        end else begin
          medium_busy_next = 1'b0;
          ev0 = queue_not_empty ? csmabo_pkg::EV_DIFS_CHECK : csmabo_pkg::EV_RECHECK;
          dk0 = csmabo_pkg::DK_DIFS_INT;
        end
      end
      csmabo_pkg::MODE_QUEUE_RECHECK: begin
        ev0 = queue_not_empty ? csmabo_pkg::EV_DIFS_CHECK : csmabo_pkg::EV_RECHECK;
        dk0 = csmabo_pkg::DK_DIFS_INT;
      end
      csmabo_pkg::MODE_STATUS_CLEAR: begin
        sending_status_next = 1'b0;
      end
      csmabo_pkg::MODE_CW_CLEAR: begin
        cw_valid_next = 1'b0;
        cw_count_next = '0;
      end
      default: ;
    endcase

    res0.next_event   = ev0;
    res0.delay_kind   = dk0;
    res0.packet_sent  = sent0;
    res0.packet_lost  = lost0;
    res0.run_ended    = ended0;
    res0.sending_flag = sending_status_next;
    res0.cw_zero_flag = cw_valid_next && (cw_count_next == '0);
    res0.last         = last0;

    // Second beat of a transmit: schedule the next access round.
    res1              = res0;
    res1.next_event   = csmabo_pkg::EV_ACCESS;
    res1.delay_kind   = csmabo_pkg::DK_TX_SLOT;
    res1.packet_sent  = 1'b0;
    res1.packet_lost  = 1'b0;
    res1.run_ended    = 1'b0;
    res1.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      medium_busy    <= 1'b0;
      difs_count     <= 3'd0;
      cw_count       <= '0;
      cw_valid       <= 1'b0;
      backoff_stage  <= 4'd0;
      retry_count    <= 8'd0;
      first_done     <= 1'b0;
      sending_status <= 1'b0;
      round_count    <= 32'd0;
    end else if (evaluate) begin
      medium_busy    <= medium_busy_next;
      difs_count     <= difs_count_next;
      cw_count       <= cw_count_next;
      cw_valid       <= cw_valid_next;
      backoff_stage  <= backoff_stage_next;
      retry_count    <= retry_count_next;
      first_done     <= first_done_next;
      sending_status <= sending_status_next;
      round_count    <= round_count_next;
    end
  end

  // Two-entry output buffer. An item is evaluated only when its one or two
  // result beats fit after this cycle's pop.
  csmabo_pkg::result_t out_buf [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] out_count;
  logic       pop;
  logic [1:0] n_results;
  logic [1:0] count_after_pop;
  logic [2:0] fill_needed;

  assign pop             = m_tvalid && m_tready;
  assign n_results       = two_results ? 2'd2 : 2'd1;
  assign count_after_pop = out_count - {1'b0, pop};
  assign fill_needed     = {1'b0, count_after_pop} + {1'b0, n_results};
  assign evaluate        = item_valid && (fill_needed <= 3'd2);

  always_ff @(posedge clk) begin
    if (evaluate) begin
      out_buf[wr_ptr] <= res0;
      if (two_results) begin
        out_buf[!wr_ptr] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (evaluate && !two_results) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      out_count <= evaluate ? fill_needed[1:0] : count_after_pop;
    end
  end

  assign m_tvalid = (out_count != 2'd0);
  assign m_tdata  = {5'd0, out_buf[rd_ptr].cw_zero_flag, out_buf[rd_ptr].sending_flag,
                     out_buf[rd_ptr].run_ended, out_buf[rd_ptr].packet_lost,
                     out_buf[rd_ptr].packet_sent, out_buf[rd_ptr].delay_kind,
                     out_buf[rd_ptr].next_event};
  assign m_tlast  = out_buf[rd_ptr].last;

endmodule
`default_nettype wire

>>> test/csmabo_checker.sv
`default_nettype none
// Watches the event and schedule streams and the register port of the backoff
// controller. It predicts every schedule beat from its own copy of the MAC
// state and compares the beats that leave the block, in order.
module csmabo_checker #(
  parameter int CW_WIDTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               sent_seen,
  output int               lost_seen,
  output int               ended_seen
);

  localparam logic [63:0] CW_MAX = (64'd1 << CW_WIDTH) - 64'd1;

  // Register copies.
  logic [9:0]          cw_min_r;
  logic [7:0]          retry_lim_r;
  logic [3:0]          stage_lim_r;
  logic [31:0]         round_lim_r;
  logic [2:0]          difs_need_r;

  // MAC state copies.
  logic                busy;
  logic [2:0]          difs_cnt;
  logic [CW_WIDTH-1:0] cw_cnt;
  logic                cw_set;
  logic [3:0]          stage;
  logic [7:0]          retries;
  logic                first_done;
  logic                sending;
  logic [31:0]         rounds;

  csmabo_pkg::result_t due_schedules[$];
  int errs, n_results, n_sent, n_lost, n_ended;

  function automatic string show(input csmabo_pkg::result_t r);
    return $sformatf("ev=%0d dk=%0d sent=%b lost=%b end=%b snd=%b cwz=%b last=%b",
                     r.next_event, r.delay_kind, r.packet_sent, r.packet_lost,
                     r.run_ended, r.sending_flag, r.cw_zero_flag, r.last);
  endfunction

  function automatic logic [CW_WIDTH-1:0] contention_draw(input logic [15:0] rnd);
    logic [63:0] win, d;
    win = 64'(cw_min_r) << stage;
    if (win <= 64'd1) d = 64'd1;
    else d = 64'd1 + ((64'(rnd) * (win - 64'd1)) >> 16);
    if (d > CW_MAX) d = CW_MAX;
    return d[CW_WIDTH-1:0];
  endfunction

  // The flags are taken from the state as it stands when the beat is queued.
  task automatic queue_schedule(input logic [2:0] ev, input logic [2:0] dk,
                                input logic sent, input logic lost,
                                input logic ended, input logic last_flag);
    csmabo_pkg::result_t r;
    r.next_event   = ev;
    r.delay_kind   = (ev != csmabo_pkg::EV_NONE) ? dk : csmabo_pkg::DK_SLOT;
    r.packet_sent  = sent;
    r.packet_lost  = lost;
    r.run_ended    = ended;
    r.sending_flag = sending;
    r.cw_zero_flag = cw_set && (cw_cnt == '0);
    r.last         = last_flag;
    due_schedules = {due_schedules, r};
  endtask

  task automatic predict_schedule(input logic [23:0] beat);
    logic [2:0] mode, clear_ev;
    logic qne, osend, ozero, coll, sent, lost, nonzero;
    logic [15:0] rnd;
    mode  = beat[2:0];
    qne   = beat[3];
    osend = beat[4];
    ozero = beat[5];
    rnd   = beat[21:6];
    case (mode)
      csmabo_pkg::MODE_DIFS_CHECK: begin
        if (!busy && difs_cnt < difs_need_r) begin
          difs_cnt = difs_cnt + 3'd1;
          if (difs_cnt == difs_need_r) begin
            difs_cnt = '0;
            if (!first_done) begin
              sending = 1'b1;
              queue_schedule(csmabo_pkg::EV_TRANSMIT, csmabo_pkg::DK_SLOT,
                             1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
              if (!cw_set) begin
                cw_cnt = contention_draw(rnd);
                cw_set = 1'b1;
              end
              queue_schedule(csmabo_pkg::EV_CW_CHECK, csmabo_pkg::DK_CW_INT,
                             1'b0, 1'b0, 1'b0, 1'b1);
            end
          end else begin
            queue_schedule(csmabo_pkg::EV_DIFS_CHECK, csmabo_pkg::DK_DIFS_INT,
                           1'b0, 1'b0, 1'b0, 1'b1);
          end
        end else begin
          difs_cnt   = '0;
          first_done = 1'b1;
          queue_schedule(csmabo_pkg::EV_DIFS_CHECK, csmabo_pkg::DK_TX,
                         1'b0, 1'b0, 1'b0, 1'b1);
        end
      end
      csmabo_pkg::MODE_CW_CHECK: begin
        nonzero = !cw_set || cw_cnt != '0;
        if (!busy && nonzero) begin
          if (cw_set) cw_cnt = cw_cnt - CW_WIDTH'(1);
          if (cw_set && cw_cnt == '0)
            queue_schedule(csmabo_pkg::EV_TRANSMIT, csmabo_pkg::DK_SLOT,
                           1'b0, 1'b0, 1'b0, 1'b1);
          else
            queue_schedule(csmabo_pkg::EV_CW_CHECK, csmabo_pkg::DK_CW_INT,
                           1'b0, 1'b0, 1'b0, 1'b1);
        end else if (busy && nonzero) begin
          queue_schedule(csmabo_pkg::EV_DIFS_CHECK, csmabo_pkg::DK_TX_CW_DIFS,
                         1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
          queue_schedule(csmabo_pkg::EV_NONE, csmabo_pkg::DK_SLOT,
                         1'b0, 1'b0, 1'b0, 1'b1);
        end
      end
      csmabo_pkg::MODE_TRANSMIT: begin
        busy = 1'b1;
        coll = 1'b0;
        sent = 1'b0;
        lost = 1'b0;
        if (!first_done) begin
          first_done = 1'b1;
          if (osend) begin
            if (retries != 8'hFF) retries = retries + 8'd1;
            coll = 1'b1;
          end
          clear_ev = csmabo_pkg::EV_STATUS_CLEAR;
        end else begin
          if (ozero) begin
            if (retries != 8'hFF) retries = retries + 8'd1;
            if (stage != 4'hF) stage = stage + 4'd1;
            coll = 1'b1;
          end
          clear_ev = csmabo_pkg::EV_CW_CLEAR;
        end
        if (coll) begin
          if (stage > stage_lim_r) stage = stage_lim_r;
          if (retries > retry_lim_r) begin
            retries = '0;
            stage   = '0;
            lost    = qne;
          end
        end else begin
          sent    = qne;
          stage   = '0;
          retries = '0;
        end
        queue_schedule(clear_ev, csmabo_pkg::DK_SLOT, sent, lost, 1'b0, 1'b0);
        queue_schedule(csmabo_pkg::EV_ACCESS, csmabo_pkg::DK_TX_SLOT,
                       1'b0, 1'b0, 1'b0, 1'b1);
      end
      csmabo_pkg::MODE_ACCESS: begin
        if (rounds != 32'hFFFF_FFFF) rounds = rounds + 32'd1;
        if (rounds >= round_lim_r) begin
          queue_schedule(csmabo_pkg::EV_NONE, csmabo_pkg::DK_SLOT,
                         1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          busy = 1'b0;
          queue_schedule(qne ? csmabo_pkg::EV_DIFS_CHECK : csmabo_pkg::EV_RECHECK,
                         csmabo_pkg::DK_DIFS_INT, 1'b0, 1'b0, 1'b0, 1'b1);
        end
      end
      csmabo_pkg::MODE_QUEUE_RECHECK: begin
        queue_schedule(qne ? csmabo_pkg::EV_DIFS_CHECK : csmabo_pkg::EV_RECHECK,
                       csmabo_pkg::DK_DIFS_INT, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      csmabo_pkg::MODE_STATUS_CLEAR: begin
        sending = 1'b0;
        queue_schedule(csmabo_pkg::EV_NONE, csmabo_pkg::DK_SLOT,
                       1'b0, 1'b0, 1'b0, 1'b1);
      end
      csmabo_pkg::MODE_CW_CLEAR: begin
        cw_set = 1'b0;
        cw_cnt = '0;
        queue_schedule(csmabo_pkg::EV_NONE, csmabo_pkg::DK_SLOT,
                       1'b0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        queue_schedule(csmabo_pkg::EV_NONE, csmabo_pkg::DK_SLOT,
                       1'b0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    csmabo_pkg::result_t got, want;
    if (rst) begin
      cw_min_r    = 10'd32;
      retry_lim_r = 8'd7;
      stage_lim_r = 4'd6;
      round_lim_r = 32'd1000;
      difs_need_r = 3'd5;
      busy        = 1'b0;
      difs_cnt    = '0;
      cw_cnt      = '0;
      cw_set      = 1'b0;
      stage       = '0;
      retries     = '0;
      first_done  = 1'b0;
      sending     = 1'b0;
      rounds      = '0;
      due_schedules.delete();
      errs = 0;
      n_results = 0;
      n_sent = 0;
      n_lost = 0;
      n_ended = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          csmabo_pkg::REG_CW_MIN:      cw_min_r    = pwdata[9:0];
          csmabo_pkg::REG_RETRY_LIMIT: retry_lim_r = pwdata[7:0];
          csmabo_pkg::REG_STAGE_LIMIT: stage_lim_r = pwdata[3:0];
          csmabo_pkg::REG_ROUND_LIMIT: round_lim_r = pwdata;
          csmabo_pkg::REG_DIFS_SLOTS:  difs_need_r = pwdata[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_schedule(s_tdata);
      if (m_tvalid && m_tready) begin
        got = csmabo_pkg::result_t'({m_tlast, m_tdata[10:0]});
        n_results++;
        n_sent  += got.packet_sent;
        n_lost  += got.packet_lost;
        n_ended += got.run_ended;
        if (due_schedules.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected schedule beat: %s", show(got));
        end else begin
          want = due_schedules.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display("schedule mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
    end
    mismatches   <= errs;
    pending      <= due_schedules.size();
    results_seen <= n_results;
    sent_seen    <= n_sent;
    lost_seen    <= n_lost;
    ended_seen   <= n_ended;
  end

endmodule
`default_nettype wire

>>> test/tb_csma_ca_backoff_controller.sv
`default_nettype none
// Stimulus and verdict for the CSMA/CA backoff controller. The checker beside
// the block predicts and compares every schedule beat; this module only makes
// event beats, register writes and output back-pressure.
module tb_csma_ca_backoff_controller;

  // Mode seven has no name in the package; the block must treat it as a no-op.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, pending, results_seen, sent_seen, lost_seen, ended_seen;

  // Idle percentages for the two sides; changed between phases.
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int beats_sent = 0;
  int settings_used = 1;

  // Shadow of the two registers that shape the well-formed access sequences.
  int cw_now = 32;
  int difs_now = 5;

  csma_ca_backoff_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  csmabo_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .sent_seen    (sent_seen),
    .lost_seen    (lost_seen),
    .ended_seen   (ended_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver drops tready at random, at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic logic rbit();
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] rword();
    return 16'($urandom);
  endfunction

  // Offers one event beat after a random gap and holds it until accepted. The
  // gap lowers tvalid one step at a time, so tvalid never sees two updates in
  // the same step; back-to-back beats simply keep tvalid high.
  task automatic send_event(input logic [2:0] mode, input logic qne, input logic osend,
                            input logic ozero, input logic [15:0] rnd);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {2'b00, rnd, ozero, osend, qne, mode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Holds off the sender until every predicted beat has come out, and keeps
  // it idle after that so that nothing can still be in flight inside the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that completes at the
  // edge where pready is seen high. psel stays up between back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_setting(input int cw, input int retry, input int stg,
                               input logic [31:0] rounds, input int difs);
    write_reg(csmabo_pkg::REG_CW_MIN, 32'(cw));
    write_reg(csmabo_pkg::REG_RETRY_LIMIT, 32'(retry));
    write_reg(csmabo_pkg::REG_STAGE_LIMIT, 32'(stg));
    write_reg(csmabo_pkg::REG_ROUND_LIMIT, rounds);
    write_reg(csmabo_pkg::REG_DIFS_SLOTS, 32'(difs));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cw_now   = cw;
    difs_now = difs;
    settings_used++;
  endtask

  // A well-formed access round as a node would see it: access, the DIFS
  // checks, a run of contention checks, the transmit, and the clears that the
  // transmit schedules. The counts are bent now and then so that DIFS is cut
  // short or overrun and the contention counter is left midway.
  task automatic access_episode();
    int n;
    send_event(csmabo_pkg::MODE_ACCESS, $urandom_range(7) != 0, rbit(), rbit(), rword());
    n = ($urandom_range(5) == 0) ? $urandom_range(difs_now + 2) : difs_now;
    repeat (n) send_event(csmabo_pkg::MODE_DIFS_CHECK, rbit(), rbit(), rbit(), rword());
    n = $urandom_range(cw_now * 3 + 2);
    if (n > 40) n = $urandom_range(40);
    repeat (n) send_event(csmabo_pkg::MODE_CW_CHECK, rbit(), rbit(), rbit(), rword());
    send_event(csmabo_pkg::MODE_TRANSMIT, $urandom_range(7) != 0, $urandom_range(2) == 0,
               $urandom_range(2) == 0, rword());
    case ($urandom_range(3))
      0: send_event(csmabo_pkg::MODE_STATUS_CLEAR, rbit(), rbit(), rbit(), rword());
      1: send_event(csmabo_pkg::MODE_CW_CLEAR, rbit(), rbit(), rbit(), rword());
      2: begin
        send_event(csmabo_pkg::MODE_STATUS_CLEAR, rbit(), rbit(), rbit(), rword());
        send_event(csmabo_pkg::MODE_CW_CLEAR, rbit(), rbit(), rbit(), rword());
      end
      default: ;
    endcase
    if ($urandom_range(3) == 0)
      send_event(csmabo_pkg::MODE_QUEUE_RECHECK, rbit(), rbit(), rbit(), rword());
  endtask

  initial begin
    int goal;
    int block_len[6];
    block_len = '{360, 360, 360, 360, 120, 360};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset register values (DIFS of five slots, window
    // of 32). The unused mode comes first and must change nothing.
    send_event(MODE_UNUSED, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    // Contention check with the counter never drawn: idle medium, so it
    // reschedules itself and the counter stays unset.
    send_event(csmabo_pkg::MODE_CW_CHECK, 1'b0, 1'b0, 1'b0, 16'h0000);
    // Events without a successor, then queue rechecks and an access that have one.
    send_event(csmabo_pkg::MODE_STATUS_CLEAR, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_CW_CLEAR, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_QUEUE_RECHECK, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_QUEUE_RECHECK, 1'b1, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_ACCESS, 1'b0, 1'b0, 1'b0, 16'h0000);
    // First attempt: a full DIFS leads straight to transmit and raises the
    // sending flag.
    repeat (5) send_event(csmabo_pkg::MODE_DIFS_CHECK, 1'b1, 1'b0, 1'b0, 16'hFFFF);
    // First-attempt collision with an empty queue: nothing is popped.
    send_event(csmabo_pkg::MODE_TRANSMIT, 1'b0, 1'b1, 1'b1, 16'hFFFF);
    // The medium is busy now, so a DIFS check fails.
    send_event(csmabo_pkg::MODE_DIFS_CHECK, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_event(csmabo_pkg::MODE_STATUS_CLEAR, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_event(csmabo_pkg::MODE_ACCESS, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    // Later attempt: a zero random value draws a counter of one, so a single
    // contention check brings it to zero and schedules transmit.
    repeat (4) send_event(csmabo_pkg::MODE_DIFS_CHECK, 1'b1, 1'b0, 1'b0, 16'hFFFF);
    send_event(csmabo_pkg::MODE_DIFS_CHECK, 1'b1, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_CW_CHECK, 1'b1, 1'b0, 1'b0, 16'h0000);
    // Counter valid and zero: no successor.
    send_event(csmabo_pkg::MODE_CW_CHECK, 1'b1, 1'b0, 1'b0, 16'h0000);
    // Clean transmit with a waiting packet: sent.
    send_event(csmabo_pkg::MODE_TRANSMIT, 1'b1, 1'b0, 1'b0, 16'h0000);
    // Busy medium with an unset-or-nonzero counter goes back to DIFS.
    send_event(csmabo_pkg::MODE_CW_CLEAR, 1'b1, 1'b0, 1'b0, 16'h0000);
    send_event(csmabo_pkg::MODE_CW_CHECK, 1'b1, 1'b0, 1'b0, 16'h0000);

    // Random part in six phases, each under its own register setting. The
    // first two stall the receiver hard, the next two starve the sender, and
    // the last two run with no idling on either side. Each phase starts from
    // an idle block, which also exercises a full drain with the sender held.
    for (int b = 0; b < 6; b++) begin
      settle();
      case (b)
        // Low extremes; the round limit is small enough to end the run
        // within the phase, after which access reports the end.
        0: apply_setting(1, 0, 0, 32'd40, 1);
        1: apply_setting(4, 3, 3, 32'hFFFF_FFFF, 7);
        // Widest minimum window and a high stage limit: long counters and big draws.
        2: apply_setting(1023, 255, 10, 32'hFFFF_FFFF, 2);
        3: apply_setting(2, 12, 10, 32'hFFFF_FFFF, 3);
        // Round limit of one: every access is past the end.
        4: apply_setting(3, 2, 4, 32'd1, 4);
        default: apply_setting($urandom_range(1, 16), $urandom_range(0, 8),
                               $urandom_range(0, 10), 32'hFFFF_FFFF,
                               $urandom_range(1, 7));
      endcase
      sender_idle_pct = (b < 2) ? 15 : (b < 4) ? 88 : 0;
      rx_stall_pct    = (b < 2) ? 88 : (b < 4) ? 15 : 0;
      goal = beats_sent + block_len[b];
      while (beats_sent < goal) begin
        // Mostly proper access rounds, with single random events as noise.
        if ($urandom_range(4) == 0)
          send_event(3'($urandom_range(7)), rbit(), rbit(), rbit(), rword());
        else
          access_episode();
      end
    end

    // Drain, then allow for anything the block might still emit late.
    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d event beats over %0d register settings, %0d schedule beats",
             beats_sent, settings_used, results_seen);
    $display("checked: %0d packets sent, %0d dropped, %0d run-end reports",
             sent_seen, lost_seen, ended_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("csma_ca_backoff_controller regression: pass");
    end else begin
      $display("csma_ca_backoff_controller regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("csma_ca_backoff_controller regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
